// File: sv/pgalloc_pkg.sv
`default_nettype none
package pgalloc_pkg;
    localparam int NUM_PAGES_DEF  = 16384;
    localparam int COUNT_BITS_DEF = 8;
    localparam int PAGE_W   = 14;
    localparam int LIMIT_W  = 15;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 15;
    localparam int QDEPTH   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 3'd0,
        REQ_FREE  = 3'd1,
        REQ_INC   = 3'd2,
        REQ_DEC   = 3'd3,
        REQ_GET   = 3'd4,
        REQ_INIT  = 3'd5
    } t_req;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PAGE_W-1:0] page;
        logic              in_range;
        logic              valid_pg;
    } t_cmd;
endpackage
`default_nettype wire

// File: sv/pgalloc_if.sv
`default_nettype none
interface pgalloc_req_if;
    logic                          valid;
    logic                          ready;
    logic [pgalloc_pkg::REQ_W-1:0]  req_type;
    logic [pgalloc_pkg::PAGE_W-1:0] page_index;
    modport source (output valid, req_type, page_index, input ready);
    modport sink   (input valid, req_type, page_index, output ready);
endinterface

interface pgalloc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pgalloc_pkg::PAGE_W-1:0]  page_out;
    logic [pgalloc_pkg::STAT_W-1:0]  status;
    logic [pgalloc_pkg::CNT_W-1:0]   ref_count;
    logic [pgalloc_pkg::LIMIT_W-1:0] free_pages;
    modport source (output valid, page_out, status, ref_count, free_pages, input ready);
    modport sink   (input valid, page_out, status, ref_count, free_pages, output ready);
endinterface
`default_nettype wire

// File: sv/pgalloc_front.sv
`default_nettype none
module pgalloc_front #(
    parameter int NUM_PAGES = pgalloc_pkg::NUM_PAGES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pgalloc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pgalloc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    pgalloc_req_if.sink                           req,
    output pgalloc_pkg::t_cmd                     o_cmd,
    output logic                                  o_cmd_valid,
    input  wire logic                             i_cmd_pop
);
    localparam int QW = $clog2(pgalloc_pkg::QDEPTH);

    logic [pgalloc_pkg::PAGE_W-1:0]  r_first;
    logic [pgalloc_pkg::LIMIT_W-1:0] r_limit;
    pgalloc_pkg::t_cmd               r_q [pgalloc_pkg::QDEPTH];
    logic [QW-1:0]                   r_wp, r_rp;
    logic [QW:0]                     r_cnt;
    pgalloc_pkg::t_cmd               n_cmd;
    logic                            push;
    logic                            vpg;

    always_comb begin
        vpg = ({7'd0, req.page_index} < 21'(NUM_PAGES));
        n_cmd.req      = req.req_type;
        n_cmd.page     = req.page_index;
        n_cmd.valid_pg = vpg;
        n_cmd.in_range = vpg && (req.page_index >= r_first) &&
                         ({1'b0, req.page_index} < r_limit);
    end

    assign req.ready   = (r_cnt != (QW+1)'(pgalloc_pkg::QDEPTH));
    assign push        = req.valid && req.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_limit <= 15'd16384;
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pgalloc_pkg::CFG_FIRST: r_first <= i_cfg_data[pgalloc_pkg::PAGE_W-1:0];
                    pgalloc_pkg::CFG_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(i_cmd_pop);
        end
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule
`default_nettype wire

// File: sv/pgalloc_back.sv
`default_nettype none
module pgalloc_back #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire pgalloc_pkg::t_cmd i_cmd,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    output logic             o_busy,
    pgalloc_rsp_if.source    rsp
);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int DW = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_RD   = 4'b0010,
        S_EX   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    logic [COUNT_BITS-1:0] r_cmem [NUM_PAGES];
    logic [AW-1:0]         r_smem [NUM_PAGES];
    t_state                r_st;
    logic [AW-1:0]         r_clr;
    logic [DW-1:0]         r_depth;
    pgalloc_pkg::t_cmd     r_cmd;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [AW-1:0]         r_top;
    logic [pgalloc_pkg::PAGE_W-1:0]  r_po;
    logic [pgalloc_pkg::STAT_W-1:0]  r_stat;
    logic [pgalloc_pkg::CNT_W-1:0]   r_rc;
    logic [pgalloc_pkg::LIMIT_W-1:0] r_fp;

    logic [AW-1:0]         pidx;
    logic [AW-1:0]         cw_a;
    logic [COUNT_BITS-1:0] cw_d, ocnt;
    logic                  cw_en, sw_en;
    logic [DW-1:0]         n_depth;
    logic [pgalloc_pkg::PAGE_W-1:0] n_po;
    logic [pgalloc_pkg::STAT_W-1:0] n_stat;

    assign pidx      = AW'(r_cmd.page);
    assign o_cmd_pop = (r_st == S_RD) && i_cmd_valid;
    assign o_busy    = (r_st != S_RD) || i_cmd_valid;
    assign rsp.valid = (r_st == S_OUT);
    assign rsp.page_out   = r_po;
    assign rsp.status     = r_stat;
    assign rsp.ref_count  = r_rc;
    assign rsp.free_pages = r_fp;

    always_comb begin
        cw_en = 1'b0; sw_en = 1'b0; cw_a = pidx; cw_d = '0;
        n_depth = r_depth; n_po = r_cmd.page; n_stat = pgalloc_pkg::ST_OK;
        ocnt = r_cnt_rd;
        case (r_cmd.req)
            pgalloc_pkg::REQ_ALLOC: begin
                if (r_depth == '0) begin
                    n_po = '0; n_stat = pgalloc_pkg::ST_EMPTY; ocnt = '0;
                end else begin
                    n_depth = r_depth - 1'b1;
                    n_po = pgalloc_pkg::PAGE_W'(r_top);
                    cw_en = 1'b1; cw_a = r_top; cw_d = COUNT_BITS'(1); ocnt = COUNT_BITS'(1);
                end
            end
            pgalloc_pkg::REQ_FREE, pgalloc_pkg::REQ_INIT: begin
                if (!r_cmd.in_range) begin
                    n_stat = pgalloc_pkg::ST_RANGE;
                    if (!r_cmd.valid_pg) ocnt = '0;
                end else if (r_cmd.req == pgalloc_pkg::REQ_INIT ||
                             r_cnt_rd <= COUNT_BITS'(1)) begin
                    cw_en = 1'b1; ocnt = '0;
                    if (r_depth >= DW'(NUM_PAGES)) n_stat = pgalloc_pkg::ST_SAT;
                    else begin
                        sw_en = 1'b1; n_depth = r_depth + 1'b1;
                    end
                end else begin
                    cw_en = 1'b1; cw_d = r_cnt_rd - 1'b1; ocnt = cw_d;
                end
            end
            pgalloc_pkg::REQ_INC: begin
                if (!r_cmd.valid_pg) begin
                    n_stat = pgalloc_pkg::ST_RANGE; ocnt = '0;
                end else if (r_cnt_rd == CMAX) n_stat = pgalloc_pkg::ST_SAT;
                else begin
                    cw_en = 1'b1; cw_d = r_cnt_rd + 1'b1; ocnt = cw_d;
                end
            end
            pgalloc_pkg::REQ_DEC: begin
                if (!r_cmd.valid_pg) begin
                    n_stat = pgalloc_pkg::ST_RANGE; ocnt = '0;
                end else if (r_cnt_rd == '0) n_stat = pgalloc_pkg::ST_SAT;
                else begin
                    cw_en = 1'b1; cw_d = r_cnt_rd - 1'b1; ocnt = cw_d;
                end
            end
            default: begin
                if (!r_cmd.valid_pg) begin
                    n_stat = pgalloc_pkg::ST_RANGE; ocnt = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_depth <= '0;
        end else begin
            case (r_st)
                S_CLR: if (r_clr == AW'(NUM_PAGES - 1)) r_st <= S_RD;
                       else r_clr <= r_clr + 1'b1;
                S_RD:  if (i_cmd_valid) r_st <= S_EX;
                S_EX: begin
                    r_depth <= n_depth;
                    r_st <= S_OUT;
                end
                S_OUT: if (rsp.ready) r_st <= S_RD;
                default: r_st <= S_RD;
            endcase
        end
        if (r_st == S_CLR) r_cmem[r_clr] <= '0;
        else if (r_st == S_EX && cw_en) r_cmem[cw_a] <= cw_d;
        if (r_st == S_EX && sw_en) r_smem[AW'(r_depth)] <= pidx;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_cnt_rd <= r_cmem[AW'(i_cmd.page)];
            r_top <= r_smem[AW'(r_depth - 1'b1)];
        end
        if (r_st == S_EX) begin
            r_po <= n_po;
            r_stat <= n_stat;
            r_rc <= pgalloc_pkg::CNT_W'(ocnt);
            r_fp <= pgalloc_pkg::LIMIT_W'(n_depth);
        end
    end
endmodule
`default_nettype wire

// File: sv/page_allocator_refcount_top.sv
`default_nettype none
// channel | dir | payload
// req     | in  | req_type, page_index
// rsp     | out | page_out, status, ref_count, free_pages
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// A request passes through count/stack read, execute and result, plus output wait.
// The single-port read-modify-write of the count and stack memories sets these steps.
// After reset a clearing pass over all NUM_PAGES entries zeroes the counts; requests
// queue in the two-entry front queue meanwhile and while a result is stalled.
module page_allocator_refcount_top #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pgalloc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pgalloc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    pgalloc_req_if.sink                            req,
    pgalloc_rsp_if.source                          rsp
);
    pgalloc_pkg::t_cmd cmd;
    logic cmd_valid, cmd_pop, busy;

    pgalloc_front #(.NUM_PAGES(NUM_PAGES)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .req(req), .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    pgalloc_back #(.NUM_PAGES(NUM_PAGES), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_cmd_pop(cmd_pop), .o_busy(busy), .rsp(rsp)
    );

    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> busy) else $error("back idle after pop");
    a_rsp_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.status == pgalloc_pkg::ST_EMPTY) |-> rsp.free_pages == '0)
        else $error("empty status with free pages");
endmodule
`default_nettype wire
